[src/plfm_pkg.sv]
// Shared types and constants for the price level FIFO matcher.
// Depends on nothing; every other file of the block but plfm_ram imports it.
`default_nettype none

package plfm_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 32;
    localparam int QTY_W     = 32;
    localparam int TOT_W     = 36;
    localparam int H_W       = 4;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_MATCH  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_UPDATE = 3'd2,
        KIND_TRADE  = 3'd3,
        KIND_DONE   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_HANDLE = 2'd2
    } t_status;

    // Request as classified by the front end.
    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  order_id;
        logic [QTY_W-1:0] qty;
        logic [H_W-1:0]   handle;
        logic             h_in_range;
    } t_cmd;

    // Per-result fields that the engine decides; level totals are added at output.
    typedef struct packed {
        t_kind            kind;
        t_status          status;
        logic [H_W-1:0]   slot;
        logic [ID_W-1:0]  resting_id;
        logic [QTY_W-1:0] fill_qty;
        logic [31:0]      trade_price;
        logic             resting_done;
        logic [QTY_W-1:0] remaining_req;
        logic             last;
    } t_res;

endpackage

`default_nettype wire

[src/plfm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module plfm_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/plfm_front.sv]
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on plfm_pkg.
`default_nettype none

module plfm_front #(
    parameter int DEPTH = plfm_pkg::DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_op,
    input  wire logic [plfm_pkg::ID_W-1:0]   i_order_id,
    input  wire logic [plfm_pkg::QTY_W-1:0]  i_qty,
    input  wire logic [plfm_pkg::H_W-1:0]    i_handle,
    output plfm_pkg::t_cmd                   o_cmd,
    output logic                             o_cmd_valid,
    input  wire logic                        i_cmd_pop
);
    import plfm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    t_cmd       c_cmd;
    logic       push, pop;

    always_comb begin
        c_cmd.op         = t_op'(i_op);
        c_cmd.order_id   = i_order_id;
        c_cmd.qty        = i_qty;
        c_cmd.handle     = i_handle;
        c_cmd.h_in_range = (32'(i_handle) < 32'(DEPTH));
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= c_cmd;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[src/plfm_back.sv]
// Back end: executes queued requests against the linked slot store and
// drives the output register. Depends on plfm_pkg and plfm_ram.
`default_nettype none

module plfm_back #(
    parameter int DEPTH = plfm_pkg::DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire plfm_pkg::t_cmd                 i_cmd,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_pop,
    input  wire logic [31:0]                    i_level_price,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output plfm_pkg::t_res                      o_res,
    output logic [plfm_pkg::TOT_W-1:0]          o_total_open,
    output logic [plfm_pkg::CNT_OUT_W-1:0]      o_order_count,
    output logic [plfm_pkg::ID_W-1:0]           o_front_id
);
    import plfm_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_RD    = 5'b00100,
        S_FRONT = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [QTY_W-1:0]   r_req, n_req;
    logic               r_stop, n_stop;
    t_res               r_res, n_res;
    logic [DEPTH-1:0]   r_occ, n_occ;
    logic [SW-1:0]      r_head, n_head;
    logic [SW-1:0]      r_tail, n_tail;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [CW-1:0]      r_count, n_count;
    logic [ID_W-1:0]    r_front_id, n_front_id;
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;
    logic [TOT_W-1:0]   r_out_total, n_out_total;
    logic [CNT_OUT_W-1:0] r_out_count, n_out_count;
    logic [ID_W-1:0]    r_out_front, n_out_front;

    logic               id_we, qty_we, nxt_we, prv_we;
    logic [SW-1:0]      id_waddr, qty_waddr, nxt_waddr, prv_waddr;
    logic [ID_W-1:0]    id_wdata;
    logic [QTY_W-1:0]   qty_wdata;
    logic [SW-1:0]      nxt_wdata, prv_wdata;
    logic [SW-1:0]      id_raddr, qty_raddr, nxt_raddr, prv_raddr;
    logic [ID_W-1:0]    id_rd;
    logic [QTY_W-1:0]   qty_rd;
    logic [SW-1:0]      nxt_rd, prv_rd;

    logic [SW-1:0]      free_s;
    logic               free_found;
    logic [SW-1:0]      hs;
    logic               hok;
    logic [SW-1:0]      cur_s;
    logic [QTY_W-1:0]   fill;
    logic               full_fill;

    plfm_ram #(.W(ID_W), .D(DEPTH)) u_id_ram (
        .i_clk(i_clk), .i_we(id_we), .i_waddr(id_waddr), .i_wdata(id_wdata),
        .i_raddr(id_raddr), .o_rdata(id_rd)
    );
    plfm_ram #(.W(QTY_W), .D(DEPTH)) u_qty_ram (
        .i_clk(i_clk), .i_we(qty_we), .i_waddr(qty_waddr), .i_wdata(qty_wdata),
        .i_raddr(qty_raddr), .o_rdata(qty_rd)
    );
    plfm_ram #(.W(SW), .D(DEPTH)) u_nxt_ram (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(nxt_raddr), .o_rdata(nxt_rd)
    );
    plfm_ram #(.W(SW), .D(DEPTH)) u_prv_ram (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_waddr), .i_wdata(prv_wdata),
        .i_raddr(prv_raddr), .o_rdata(prv_rd)
    );

    // Lowest free slot.
    always_comb begin
        free_s     = '0;
        free_found = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (!free_found && !r_occ[i]) begin
                free_s     = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign hs        = SW'(r_cmd.handle);
    assign hok       = r_cmd.h_in_range && r_occ[hs];
    assign cur_s     = (r_cmd.op == OP_MATCH) ? r_head : hs;
    assign fill      = (qty_rd < r_req) ? qty_rd : r_req;
    assign full_fill = (fill == qty_rd);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_req       = r_req;
        n_stop      = r_stop;
        n_res       = r_res;
        n_occ       = r_occ;
        n_head      = r_head;
        n_tail      = r_tail;
        n_total     = r_total;
        n_count     = r_count;
        n_front_id  = r_front_id;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_out_total = r_out_total;
        n_out_count = r_out_count;
        n_out_front = r_out_front;
        o_cmd_pop   = 1'b0;
        id_we       = 1'b0;
        qty_we      = 1'b0;
        nxt_we      = 1'b0;
        prv_we      = 1'b0;
        id_waddr    = '0;
        qty_waddr   = '0;
        nxt_waddr   = '0;
        prv_waddr   = '0;
        id_wdata    = r_cmd.order_id;
        qty_wdata   = r_cmd.qty;
        nxt_wdata   = '0;
        prv_wdata   = '0;
        id_raddr    = cur_s;
        qty_raddr   = cur_s;
        nxt_raddr   = cur_s;
        prv_raddr   = cur_s;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_req     = i_cmd.qty;
                    n_stop    = 1'b0;
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res      = '0;
                n_res.last = 1'b1;
                n_state    = S_EMIT;
                unique case (r_cmd.op)
                    OP_ADD: begin
                        n_res.kind = KIND_ADD;
                        if (32'(r_count) >= 32'(DEPTH) || !free_found) begin
                            n_res.status = ST_FULL;
                        end else begin
                            id_we      = 1'b1;
                            id_waddr   = free_s;
                            qty_we     = 1'b1;
                            qty_waddr  = free_s;
                            n_occ[free_s] = 1'b1;
                            if (r_count == '0) begin
                                n_head     = free_s;
                                n_front_id = r_cmd.order_id;
                            end else begin
                                nxt_we    = 1'b1;
                                nxt_waddr = r_tail;
                                nxt_wdata = free_s;
                                prv_we    = 1'b1;
                                prv_waddr = free_s;
                                prv_wdata = r_tail;
                            end
                            n_tail     = free_s;
                            n_count    = r_count + CW'(1);
                            n_total    = r_total + TOT_W'(r_cmd.qty);
                            n_res.slot = H_W'(free_s);
                        end
                    end
                    OP_REMOVE, OP_UPDATE: begin
                        n_res.kind = (r_cmd.op == OP_REMOVE) ? KIND_REMOVE : KIND_UPDATE;
                        n_res.slot = r_cmd.handle;
                        if (!hok) begin
                            n_res.status = ST_BAD_HANDLE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    OP_MATCH: begin
                        if (r_count == '0 || r_req == '0 || r_stop) begin
                            n_res.kind          = KIND_DONE;
                            n_res.remaining_req = r_req;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                endcase
            end

            S_RD: begin
                n_state = S_EMIT;
                if (r_cmd.op == OP_UPDATE) begin
                    n_total   = r_total - TOT_W'(qty_rd) + TOT_W'(r_cmd.qty);
                    qty_we    = 1'b1;
                    qty_waddr = hs;
                end else begin
                    if (r_cmd.op == OP_MATCH) begin
                        n_res               = '0;
                        n_res.kind          = KIND_TRADE;
                        n_res.slot          = H_W'(r_head);
                        n_res.resting_id    = id_rd;
                        n_res.fill_qty      = fill;
                        n_res.trade_price   = i_level_price;
                        n_res.resting_done  = full_fill;
                        n_res.remaining_req = r_req - fill;
                        n_req               = r_req - fill;
                    end
                    if (r_cmd.op == OP_MATCH && !full_fill) begin
                        // Partial fill: the order keeps its place with less open.
                        qty_we    = 1'b1;
                        qty_waddr = r_head;
                        qty_wdata = qty_rd - fill;
                        n_total   = r_total - TOT_W'(fill);
                        n_stop    = 1'b1;
                    end else begin
                        n_occ[cur_s] = 1'b0;
                        n_total      = r_total - TOT_W'(qty_rd);
                        n_count      = r_count - CW'(1);
                        if (r_count <= CW'(1)) begin
                            n_head = '0;
                            n_tail = '0;
                        end else if (cur_s == r_head) begin
                            // Head moves on; fetch the new oldest id.
                            n_head   = nxt_rd;
                            id_raddr = nxt_rd;
                            n_state  = S_FRONT;
                        end else if (cur_s == r_tail) begin
                            n_tail = prv_rd;
                        end else begin
                            nxt_we    = 1'b1;
                            nxt_waddr = prv_rd;
                            nxt_wdata = nxt_rd;
                            prv_we    = 1'b1;
                            prv_waddr = nxt_rd;
                            prv_wdata = prv_rd;
                        end
                    end
                end
            end

            S_FRONT: begin
                n_front_id = id_rd;
                n_state    = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_total = r_total;
                    n_out_count = CNT_OUT_W'(r_count);
                    n_out_front = (r_count != '0) ? r_front_id : '0;
                    // After a trade the match loop checks whether to go on.
                    n_state     = (r_res.kind == KIND_TRADE) ? S_EXEC : S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_req       <= n_req;
        r_res       <= n_res;
        r_front_id  <= n_front_id;
        r_out       <= n_out;
        r_out_total <= n_out_total;
        r_out_count <= n_out_count;
        r_out_front <= n_out_front;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stop      <= 1'b0;
            r_occ       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stop      <= n_stop;
            r_occ       <= n_occ;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_total     <= n_total;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_res         = r_out;
    assign o_total_open  = r_out_total;
    assign o_order_count = r_out_count;
    assign o_front_id    = r_out_front;

endmodule

`default_nettype wire

[src/price_level_fifo_matcher.sv]
// One price level of an order book: time-ordered resting orders and matching.
// Top level; depends on plfm_pkg, plfm_front, plfm_back (which uses plfm_ram).
//
// Requests come in on a valid/ready channel (op, order_id, qty, handle) and are
// taken into a two-entry queue, so the sender can go on while the engine works.
// Results leave through one output register on a valid/ready channel; o_last
// marks the final result of a request.
// From the queue to the output register, add and a failed remove or update pass
// through the states EXEC and EMIT; remove and update pass through EXEC, RD and
// EMIT, with FRONT before EMIT when the oldest order is removed. A match is taken
// in IDLE, then passes through EXEC, RD and EMIT per trade (with FRONT when the
// oldest order leaves and the new head id is fetched from the id memory) and through
// EXEC and EMIT for its done item. One request is worked on at a time.
// If the receiver stalls, the engine holds its next result and stops; the input
// queue keeps taking requests until it is full. Reset (synchronous, active low)
// empties the level and both channels; the level price is written through
// i_cfg_we / i_cfg_wdata while idle, a user rule the block does not enforce.
`default_nettype none

module price_level_fifo_matcher #(
    parameter int DEPTH = plfm_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [31:0]                   i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_op,
    input  wire logic [plfm_pkg::ID_W-1:0]     i_order_id,
    input  wire logic [plfm_pkg::QTY_W-1:0]    i_qty,
    input  wire logic [plfm_pkg::H_W-1:0]      i_handle,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_kind,
    output logic [1:0]                         o_status,
    output logic [plfm_pkg::H_W-1:0]           o_slot,
    output logic [plfm_pkg::ID_W-1:0]          o_resting_id,
    output logic [plfm_pkg::QTY_W-1:0]         o_fill_qty,
    output logic [31:0]                        o_trade_price,
    output logic                               o_resting_done,
    output logic [plfm_pkg::QTY_W-1:0]         o_remaining_req,
    output logic [plfm_pkg::TOT_W-1:0]         o_total_open,
    output logic [plfm_pkg::CNT_OUT_W-1:0]     o_order_count,
    output logic [plfm_pkg::ID_W-1:0]          o_front_id,
    output logic                               o_last
);
    import plfm_pkg::*;

    logic [31:0] r_level_price;
    t_cmd        cmd;
    logic        cmd_valid;
    logic        cmd_pop;
    t_res        res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_price <= '0;
        end else if (i_cfg_we) begin
            r_level_price <= i_cfg_wdata;
        end
    end

    plfm_front #(.DEPTH(DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op(i_op), .i_order_id(i_order_id), .i_qty(i_qty), .i_handle(i_handle),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );

    plfm_back #(.DEPTH(DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop),
        .i_level_price(r_level_price),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_res(res), .o_total_open(o_total_open),
        .o_order_count(o_order_count), .o_front_id(o_front_id)
    );

    assign o_kind          = res.kind;
    assign o_status        = res.status;
    assign o_slot          = res.slot;
    assign o_resting_id    = res.resting_id;
    assign o_fill_qty      = res.fill_qty;
    assign o_trade_price   = res.trade_price;
    assign o_resting_done  = res.resting_done;
    assign o_remaining_req = res.remaining_req;
    assign o_last          = res.last;

    // A trade is never the final result of its request and carries the level price.
    a_trade_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_TRADE) |-> (!o_last && o_trade_price == r_level_price))
        else $error("trade result marked last or with wrong price");

    // Every other result ends its request.
    a_other_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_TRADE) |-> o_last)
        else $error("non-trade result not marked last");

    // An empty level shows no front order and no open quantity.
    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_order_count == '0) |-> (o_front_id == '0 && o_total_open == '0))
        else $error("empty level reports front id or open quantity");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench for price_level_fifo_matcher, random and directed order requests checked
// against a behavioral model of one price level. Depends on plfm_pkg and the top.
module tb_top;
    import plfm_pkg::*;

    typedef struct {
        t_op         op;
        logic [31:0] order_id;
        logic [31:0] qty;
        logic [3:0]  handle;
    } t_req;

    typedef struct {
        t_kind       kind;
        t_status     status;
        logic [3:0]  slot;
        logic [31:0] resting_id;
        logic [31:0] fill_qty;
        logic [31:0] trade_price;
        logic        resting_done;
        logic [31:0] remaining_req;
        logic [35:0] total_open;
        logic [4:0]  order_count;
        logic [31:0] front_id;
        logic        last;
    } t_result;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [31:0] i_cfg_wdata = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [1:0]  i_op = 0;
    logic [31:0] i_order_id = 0;
    logic [31:0] i_qty = 0;
    logic [3:0]  i_handle = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [2:0]  o_kind;
    logic [1:0]  o_status;
    logic [3:0]  o_slot;
    logic [31:0] o_resting_id, o_fill_qty, o_trade_price, o_remaining_req, o_front_id;
    logic        o_resting_done, o_last;
    logic [35:0] o_total_open;
    logic [4:0]  o_order_count;

    price_level_fifo_matcher uut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow of the level.
    logic [31:0] lvl_price;
    logic [31:0] bk_id [16];
    logic [31:0] bk_qty [16];
    logic        bk_used [16];
    int          fifo_order[$];   // slot numbers, oldest first
    logic [35:0] bk_total;

    t_req    pending_reqs[$];
    t_result expected_results[$];
    int      send_idle_pct = 0, recv_stall_pct = 0, hold_off = 0;
    logic    hold_go = 0;
    int      errors = 0;

    function automatic t_result blank_result(t_kind k);
        t_result r;
        r = '{kind: k, status: ST_OK, slot: 0, resting_id: 0, fill_qty: 0,
              trade_price: 0, resting_done: 0, remaining_req: 0, total_open: 0,
              order_count: 0, front_id: 0, last: 0};
        return r;
    endfunction

    function automatic void post_result(t_result r);
        r.total_open  = bk_total;
        r.order_count = 5'(fifo_order.size());
        r.front_id    = fifo_order.size() > 0 ? bk_id[fifo_order[0]] : 32'd0;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void drop_slot(int s);
        foreach (fifo_order[i])
            if (fifo_order[i] == s) begin
                fifo_order.delete(i);
                break;
            end
        bk_used[s] = 0;
        bk_total = bk_total - bk_qty[s];
    endfunction

    function automatic void predict_level(t_req q);
        t_result r;
        int s;
        logic [31:0] req, fill, avail;
        r = blank_result(KIND_ADD);
        r.last = 1;
        case (q.op)
            OP_ADD: begin
                s = 0;
                while (s < 16 && bk_used[s]) s++;
                if (s >= 16) begin
                    r.status = ST_FULL;
                end else begin
                    bk_id[s] = q.order_id;
                    bk_qty[s] = q.qty;
                    bk_used[s] = 1;
                    fifo_order.insert(fifo_order.size(), s);
                    bk_total = bk_total + q.qty;
                    r.slot = 4'(s);
                end
                post_result(r);
            end
            OP_REMOVE, OP_UPDATE: begin
                r.kind = (q.op == OP_REMOVE) ? KIND_REMOVE : KIND_UPDATE;
                r.slot = q.handle;
                if (!bk_used[q.handle]) begin
                    r.status = ST_BAD_HANDLE;
                end else if (q.op == OP_REMOVE) begin
                    drop_slot(q.handle);
                end else begin
                    bk_total = bk_total - bk_qty[q.handle] + q.qty;
                    bk_qty[q.handle] = q.qty;
                end
                post_result(r);
            end
            default: begin
                req = q.qty;
                while (fifo_order.size() > 0 && req > 0) begin
                    s = fifo_order[0];
                    avail = bk_qty[s];
                    fill = avail < req ? avail : req;
                    req = req - fill;
                    r = blank_result(KIND_TRADE);
                    r.slot = 4'(s);
                    r.resting_id = bk_id[s];
                    r.fill_qty = fill;
                    r.trade_price = lvl_price;
                    r.remaining_req = req;
                    if (fill == avail) begin
                        drop_slot(s);
                        r.resting_done = 1;
                        post_result(r);
                    end else begin
                        bk_qty[s] = avail - fill;
                        bk_total = bk_total - fill;
                        post_result(r);
                        break;
                    end
                end
                r = blank_result(KIND_DONE);
                r.remaining_req = req;
                r.last = 1;
                post_result(r);
            end
        endcase
    endfunction

    // Driver: prediction happens at acceptance, so config order is preserved.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_level('{t_op'(i_op), i_order_id, i_qty, i_handle});
                void'(pending_reqs.pop_front());
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if ((i_in_valid && o_in_ready ? pending_reqs.size() > 0
                                              : pending_reqs.size() > 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1;
                    i_op       <= pending_reqs[0].op;
                    i_order_id <= pending_reqs[0].order_id;
                    i_qty      <= pending_reqs[0].qty;
                    i_handle   <= pending_reqs[0].handle;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles.
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_off <= 300;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Receiver and result checker.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result kind %0d", o_kind);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_kind !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, o_kind); errors++; end
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); errors++; end
                    if (o_slot !== e.slot) begin
                        $error("slot exp %0d got %0d", e.slot, o_slot); errors++; end
                    if (o_resting_id !== e.resting_id) begin
                        $error("resting_id exp %0h got %0h", e.resting_id, o_resting_id);
                        errors++;
                    end
                    if (o_fill_qty !== e.fill_qty) begin
                        $error("fill_qty exp %0h got %0h", e.fill_qty, o_fill_qty); errors++; end
                    if (o_trade_price !== e.trade_price) begin
                        $error("trade_price exp %0h got %0h", e.trade_price, o_trade_price);
                        errors++;
                    end
                    if (o_resting_done !== e.resting_done) begin
                        $error("resting_done exp %0d got %0d", e.resting_done, o_resting_done);
                        errors++;
                    end
                    if (o_remaining_req !== e.remaining_req) begin
                        $error("remaining_req exp %0h got %0h", e.remaining_req,
                               o_remaining_req);
                        errors++;
                    end
                    if (o_total_open !== e.total_open) begin
                        $error("total_open exp %0h got %0h", e.total_open, o_total_open);
                        errors++;
                    end
                    if (o_order_count !== e.order_count) begin
                        $error("order_count exp %0d got %0d", e.order_count, o_order_count);
                        errors++;
                    end
                    if (o_front_id !== e.front_id) begin
                        $error("front_id exp %0h got %0h", e.front_id, o_front_id); errors++; end
                    if (o_last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_last); errors++; end
                end
            end
            if (hold_go || hold_off > 0) begin
                i_out_ready <= 0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    function automatic void queue_req(t_op op, logic [31:0] id, logic [31:0] qty,
                                      logic [3:0] h);
        t_req q;
        q = '{op, id, qty, h};
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    task automatic drain_and_config(logic [31:0] price);
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= price;
        lvl_price = price;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_burst(int n);
        int k;
        t_op op;
        for (k = 0; k < n; k++) begin
            op = t_op'($urandom_range(3));
            // Handles are uniform over all slots, so both live and free slots are hit.
            queue_req(op, $urandom, rand_qty(), 4'($urandom_range(15)));
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < 16; k++) bk_used[k] = 0;
        bk_total = 0;
        lvl_price = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        drain_and_config(32'hFFFF_FFFF);

        // Directed: zero match on empty, bad handles, fill to full, overflow,
        // update to zero, middle remove, partial and exhausting matches.
        queue_req(OP_MATCH, 0, 0, 0);
        queue_req(OP_MATCH, 0, 5, 0);
        queue_req(OP_REMOVE, 0, 0, 4'hF);
        queue_req(OP_UPDATE, 0, 7, 0);
        for (k = 0; k < 16; k++)
            queue_req(OP_ADD, k == 0 ? 32'hFFFF_FFFF : $urandom,
                      k == 1 ? 32'hFFFF_FFFF : 32'(k == 2 ? 0 : 10 + k), 4'(k));
        queue_req(OP_ADD, 32'h1234, 1, 0);
        queue_req(OP_UPDATE, 0, 0, 3);
        queue_req(OP_REMOVE, 0, 0, 5);
        queue_req(OP_MATCH, 0, 32'hFFFF_FFFF, 0);
        queue_req(OP_MATCH, 0, 32'hFFFF_FFFF, 0);
        drain_and_config(0);

        send_idle_pct = 78;
        random_burst(55);
        drain_and_config($urandom);
        send_idle_pct = 0; recv_stall_pct = 78;
        random_burst(55);
        drain_and_config(32'h8000_0001);
        send_idle_pct = 9; recv_stall_pct = 9;
        random_burst(55);
        // Long receiver hold-off while the sender keeps offering.
        @(posedge i_clk);
        send_idle_pct = 0; recv_stall_pct = 0;
        random_burst(40);
        hold_go <= 1;
        @(posedge i_clk);
        hold_go <= 0;
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule

[files.f]
src/plfm_pkg.sv
src/plfm_ram.sv
src/plfm_front.sv
src/plfm_back.sv
src/price_level_fifo_matcher.sv
bench/tb_top.sv
